/* design/desp_pkg.sv */
// Package for the distance-error speed profile: widths, register indexes and
// pipeline geometry. No dependencies.
`default_nettype none

package desp_pkg;

  localparam int ErrW   = 32;
  localparam int BandW  = 24;
  localparam int SpeedW = 7;
  localparam int OutW   = 8;
  localparam int ProdW  = BandW + SpeedW;
  localparam int DivBits = 7;          // quotient < max - min <= 100
  localparam int IdxW   = 2;
  localparam int NumStg = DivBits + 3; // front, multiply, divide steps, output

  localparam logic [SpeedW-1:0] PctLimit = SpeedW'(100);

  typedef enum logic [IdxW-1:0] {
    RegMinSpeed = 2'd0,
    RegMaxSpeed = 2'd1,
    RegSlowBand = 2'd2
  } reg_idx_e;

  // front stage: sign, zero flag, magnitude
  typedef struct packed {
    logic            neg;
    logic            zero;
    logic [ErrW-1:0] mag;
  } front_t;

  // divide stages: partial remainder and quotient bits so far
  typedef struct packed {
    logic               neg;
    logic               zero;
    logic               sat;
    logic [ProdW-1:0]   rem;
    logic [DivBits-1:0] quo;
  } div_t;

  function automatic logic [SpeedW-1:0] sat_pct(logic [SpeedW-1:0] v);
    return (v > PctLimit) ? PctLimit : v;
  endfunction

endpackage

`default_nettype wire

/* design/distance_error_speed_profile.sv */
// Distance-error speed profile: linear deceleration ramp, fully pipelined.
// Depends on desp_pkg.
//
//  channel   dir  fields (lsb first)             handshake
//  s_axis    in   tdata[31:0] error_mm           tvalid/tready
//  m_axis    out  tdata[7:0]  speed_pct          tvalid/tready
//  cfg       in   idx 0 min, 1 max, 2 band       cfg_we_i, no wait
//
// Ten register stages: magnitude, compare and 24x7 multiply, seven restoring
// divide steps (one quotient bit each, set by the compare/subtract against
// the band), then offset, sign and clamp. One beat per cycle unless m_axis_tready stalls the pipe.
// Each stage loads when empty or when the next one moves, so bubbles close
// up and input is taken while a result waits. Reset empties the pipe and
// loads the register defaults.
`default_nettype none

module distance_error_speed_profile
  import desp_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [ErrW-1:0]     s_axis_tdata,   // [31:0] error_mm
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutW-1:0]          m_axis_tdata,   // [7:0] speed_pct
  input  wire logic                cfg_we_i,
  input  wire logic [IdxW-1:0]     cfg_idx_i,
  input  wire logic [BandW-1:0]    cfg_wdata_i
);

  logic [SpeedW-1:0] min_speed_q, max_speed_q;
  logic [BandW-1:0]  slow_band_q;
  logic [SpeedW-1:0] lo, hi;

  logic [NumStg-1:0] v_q;
  logic [NumStg-1:0] rdy;

  front_t            front_q, front_d;
  div_t              mul_q, mul_d;
  div_t              div_q [DivBits];
  logic [OutW-1:0]   out_q, out_d;

  // ---------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q <= SpeedW'(10);
      max_speed_q <= SpeedW'(100);
      slow_band_q <= BandW'(100);
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegMinSpeed: min_speed_q <= cfg_wdata_i[SpeedW-1:0];
        RegMaxSpeed: max_speed_q <= cfg_wdata_i[SpeedW-1:0];
        RegSlowBand: slow_band_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign lo = sat_pct(min_speed_q);
  assign hi = sat_pct(max_speed_q);

  // ---------------- flow control
  always_comb begin
    rdy[NumStg-1] = !v_q[NumStg-1] || m_axis_tready;
    for (int k = NumStg - 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = v_q[NumStg-1];
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (rdy[0]) v_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NumStg; k++) begin
        if (rdy[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // ---------------- stage 0: magnitude
  always_comb begin
    front_d.neg  = s_axis_tdata[ErrW-1];
    front_d.zero = (s_axis_tdata == '0);
    front_d.mag  = s_axis_tdata[ErrW-1] ? (ErrW'(0) - s_axis_tdata) : s_axis_tdata;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) front_q <= front_d;
  end

  // ---------------- stage 1: band compare and multiply
  always_comb begin
    mul_d.neg  = front_q.neg;
    mul_d.zero = front_q.zero;
    mul_d.sat  = (front_q.mag >= {{(ErrW-BandW){1'b0}}, slow_band_q}) || (lo > hi);
    mul_d.rem  = {{SpeedW{1'b0}}, front_q.mag[BandW-1:0]}
               * {{BandW{1'b0}}, hi - lo};
    mul_d.quo  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) mul_q <= mul_d;
  end

  // ---------------- stages 2..8: one quotient bit per stage, msb first
  for (genvar j = 0; j < DivBits; j++) begin : g_div
    localparam int Sh = DivBits - 1 - j;
    div_t             prev, nxt;
    logic [ProdW-1:0] dsr;

    assign prev = (j == 0) ? mul_q : div_q[(j == 0) ? 0 : j - 1];
    assign dsr  = ProdW'(slow_band_q) << Sh;

    always_comb begin
      nxt = prev;
      if (prev.rem >= dsr) begin
        nxt.rem     = prev.rem - dsr;
        nxt.quo[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j+2]) div_q[j] <= nxt;
    end
  end

  // ---------------- last stage: offset, clamp, sign
  always_comb begin
    logic [OutW-1:0] sp;
    div_t            d;
    d  = div_q[DivBits-1];
    sp = d.sat ? {1'b0, hi} : ({1'b0, lo} + {1'b0, d.quo});
    if (sp > {1'b0, hi}) sp = {1'b0, hi};
    if (d.zero)     out_d = '0;
    else if (d.neg) out_d = OutW'(0) - sp;
    else            out_d = sp;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NumStg-1]) out_q <= out_d;
  end

`ifndef SYNTH
  // a result never exceeds full speed either way
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata) <= 100 && $signed(m_axis_tdata) >= -100))
    else $error("speed out of range");

  // the input side only stalls when every stage is full behind a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready && (&v_q)))
    else $error("input stalled with room in the pipe");

  // after the last divide step the remainder is below the band
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[NumStg-2] && !div_q[DivBits-1].sat && !div_q[DivBits-1].zero)
      |-> (div_q[DivBits-1].rem < ProdW'(slow_band_q)))
    else $error("divide remainder not reduced");
`endif

endmodule

`default_nettype wire
